@@ rtl/cba_pkg.sv @@
package cba_pkg;

	// Fixed widths of the external fields.
	localparam int unsigned FID_W      = 16;
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned SIZE_W     = 7;
	localparam int unsigned CNT_REG_W  = 7;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [APB_ADDR_W-1:0] REG_BLOCK_COUNT = 3'd0;
	localparam logic [CNT_REG_W-1:0]  BLOCK_COUNT_RST = 7'd64;

	localparam logic OP_ALLOC  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		ST_CREATED   = 3'd0,
		ST_NO_SPACE  = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EXHAUSTED = 3'd4
	} status_t;

	// Control from the sequencer to the owner table.
	typedef struct packed {
		logic rd;
		logic wr;
	} store_ctl_t;

endpackage

@@ rtl/cba_store.sv @@
module cba_store #(
	parameter int MAX_BLOCKS = 64,
	parameter int ID_BITS    = 16,
	parameter int AW         = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cba_pkg::store_ctl_t     ctl,
	input  logic [AW-1:0]           addr,
	input  logic [ID_BITS-1:0]      wdata,
	output logic [ID_BITS-1:0]      rdata
);

	logic [ID_BITS-1:0]    mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] valid_q;
	logic [ID_BITS-1:0]    rd_data_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rd_data_q <= mem[addr];
		end
	end

	// A block never written since reset reads as free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.wr) begin
				valid_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_vld_q <= valid_q[addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_data_q : '0;

endmodule

@@ rtl/cba_seq.sv @@
module cba_seq #(
	parameter int MAX_BLOCKS = 64,
	parameter int ID_BITS    = 16,
	parameter int AW         = 6,
	parameter int CNT_W      = 7
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            opcode,
	input  logic [cba_pkg::SIZE_W-1:0]      request_size,
	input  logic [cba_pkg::FID_W-1:0]       query_id,
	input  logic [CNT_W-1:0]                blocks,
	output logic                            busy,
	output cba_pkg::store_ctl_t             ctl,
	output logic [AW-1:0]                   addr,
	output logic [ID_BITS-1:0]              wdata,
	input  logic [ID_BITS-1:0]              rdata,
	output logic                            result_valid,
	output cba_pkg::status_t                status,
	output logic [cba_pkg::FID_W-1:0]       file_id,
	output logic [cba_pkg::IDX_W-1:0]       block_index,
	output logic                            last
);

	localparam int CW = ((ID_BITS > cba_pkg::FID_W) ? ID_BITS : cba_pkg::FID_W) + 1;

	typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SCAN, S_FILL} state_t;

	state_t                       state_q;
	logic                         op_q;
	logic [cba_pkg::SIZE_W-1:0]   size_q;
	logic [cba_pkg::FID_W-1:0]    qid_q;
	logic [ID_BITS:0]             next_id_q;
	logic [CNT_W-1:0]             issue_q;
	logic                         dv_q;
	logic [AW-1:0]                didx_q;
	logic [CNT_W-1:0]             run_q;
	logic                         found_q;
	logic [AW-1:0]                end_q;
	logic [AW-1:0]                wptr_q;
	logic                         pend_v_q;
	logic [AW-1:0]                pend_idx_q;
	logic                         result_valid_q;
	cba_pkg::status_t             status_q;
	logic [cba_pkg::FID_W-1:0]    file_id_q;
	logic [cba_pkg::IDX_W-1:0]    block_index_q;
	logic                         last_q;

	logic                         rd;
	logic [CW-1:0]                cmp_ref;
	logic                         cmp_eq;
	logic                         is_free;
	logic                         is_match;
	logic [CNT_W-1:0]             run_nxt;
	logic [cba_pkg::SIZE_W-1:0]   fill_start;
	logic                         exhausted;
	logic                         unissued;

	assign rd         = (state_q == S_SCAN) && (issue_q < blocks);
	assign ctl.rd     = rd;
	assign ctl.wr     = (state_q == S_FILL);
	assign addr       = rd ? issue_q[AW-1:0] : wptr_q;
	assign wdata      = next_id_q[ID_BITS-1:0];

	// One comparator serves both the free test and the id match.
	assign cmp_ref    = (op_q == cba_pkg::OP_ALLOC) ? '0 : CW'(qid_q);
	assign cmp_eq     = (CW'(rdata) == cmp_ref);
	assign is_free    = cmp_eq;
	assign is_match   = cmp_eq;
	assign run_nxt    = run_q + 1'b1;
	assign fill_start = cba_pkg::SIZE_W'(end_q) - size_q + 7'd1;
	assign exhausted  = next_id_q[ID_BITS];
	assign unissued   = (qid_q == '0) || (CW'(qid_q) >= CW'(next_id_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= cba_pkg::OP_ALLOC;
			size_q         <= '0;
			qid_q          <= '0;
			next_id_q      <= (ID_BITS+1)'(1);
			issue_q        <= '0;
			dv_q           <= 1'b0;
			didx_q         <= '0;
			run_q          <= '0;
			found_q        <= 1'b0;
			end_q          <= '0;
			wptr_q         <= '0;
			pend_v_q       <= 1'b0;
			pend_idx_q     <= '0;
			result_valid_q <= 1'b0;
			status_q       <= cba_pkg::ST_CREATED;
			file_id_q      <= '0;
			block_index_q  <= '0;
			last_q         <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= opcode;
						size_q   <= request_size;
						qid_q    <= query_id;
						issue_q  <= '0;
						dv_q     <= 1'b0;
						run_q    <= '0;
						found_q  <= 1'b0;
						pend_v_q <= 1'b0;
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (op_q == cba_pkg::OP_ALLOC && exhausted) begin
						result_valid_q <= 1'b1;
						status_q       <= cba_pkg::ST_EXHAUSTED;
						file_id_q      <= '0;
						block_index_q  <= '0;
						last_q         <= 1'b1;
						state_q        <= S_IDLE;
					end else if (op_q == cba_pkg::OP_SEARCH && unissued) begin
						result_valid_q <= 1'b1;
						status_q       <= cba_pkg::ST_NOT_FOUND;
						file_id_q      <= qid_q;
						block_index_q  <= '0;
						last_q         <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd) begin
						issue_q <= issue_q + 1'b1;
					end
					dv_q   <= rd;
					didx_q <= issue_q[AW-1:0];
					if (dv_q) begin
						if (op_q == cba_pkg::OP_ALLOC) begin
							if (is_free) begin
								run_q <= run_nxt;
								if (cba_pkg::SIZE_W'(run_nxt) == size_q) begin
									found_q <= 1'b1;
									end_q   <= didx_q;
								end
							end else begin
								run_q <= '0;
							end
						end else if (is_match) begin
							// The previous match is now known not to be the final one.
							if (pend_v_q) begin
								result_valid_q <= 1'b1;
								status_q       <= cba_pkg::ST_FOUND;
								file_id_q      <= qid_q;
								block_index_q  <= cba_pkg::IDX_W'(pend_idx_q);
								last_q         <= 1'b0;
							end
							pend_v_q   <= 1'b1;
							pend_idx_q <= didx_q;
						end
					end else if (!rd) begin
						if (op_q == cba_pkg::OP_ALLOC) begin
							if (found_q && size_q != '0) begin
								wptr_q  <= fill_start[AW-1:0];
								state_q <= S_FILL;
							end else begin
								result_valid_q <= 1'b1;
								status_q       <= cba_pkg::ST_NO_SPACE;
								file_id_q      <= '0;
								block_index_q  <= '0;
								last_q         <= 1'b1;
								state_q        <= S_IDLE;
							end
						end else begin
							result_valid_q <= 1'b1;
							status_q       <= pend_v_q ? cba_pkg::ST_FOUND
							                           : cba_pkg::ST_NOT_FOUND;
							file_id_q      <= qid_q;
							block_index_q  <= pend_v_q ? cba_pkg::IDX_W'(pend_idx_q) : '0;
							last_q         <= 1'b1;
							state_q        <= S_IDLE;
						end
					end
				end
				S_FILL: begin
					if (wptr_q == end_q) begin
						result_valid_q <= 1'b1;
						status_q       <= cba_pkg::ST_CREATED;
						file_id_q      <= cba_pkg::FID_W'(next_id_q);
						block_index_q  <= '0;
						last_q         <= 1'b1;
						next_id_q      <= next_id_q + 1'b1;
						state_q        <= S_IDLE;
					end else begin
						wptr_q <= wptr_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign file_id      = file_id_q;
	assign block_index  = block_index_q;
	assign last         = last_q;

endmodule

@@ rtl/contiguous_block_allocator.sv @@
// Channel   Handshake                      Payload
// -------   ----------------------------   ------------------------------------
// request   start, busy (taken: start&!busy) opcode, request_size, query_id
// result    result_valid (one cycle)       status, file_id, block_index, last
// config    APB psel/penable/pwrite/pready paddr, pwdata, prdata (block_count)
//
// Every block in use (block_count capped at MAX_BLOCKS) is read once through
// the single read port of the owner table; an allocate that succeeds then
// writes its request_size blocks. An allocate with the ids used up or a search
// for an unissued id is answered without reading the table.
// busy falls as the final result is shown, so the next item can be taken then.
// After reset all blocks read as free at once through per-block valid bits.
// The receiver cannot stall: each result is shown for exactly one cycle.
module contiguous_block_allocator #(
	parameter int MAX_BLOCKS = 64,
	parameter int ID_BITS    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cba_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [cba_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [cba_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	input  logic                                start,
	output logic                                busy,
	input  logic                                opcode,
	input  logic [cba_pkg::SIZE_W-1:0]          request_size,
	input  logic [cba_pkg::FID_W-1:0]           query_id,
	output logic                                result_valid,
	output logic [2:0]                          status,
	output logic [cba_pkg::FID_W-1:0]           file_id,
	output logic [cba_pkg::IDX_W-1:0]           block_index,
	output logic                                last
);

	localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	logic [cba_pkg::CNT_REG_W-1:0] block_count_q;
	logic [CNT_W-1:0]              blocks;
	cba_pkg::store_ctl_t           ctl;
	logic [AW-1:0]                 addr;
	logic [ID_BITS-1:0]            wdata;
	logic [ID_BITS-1:0]            rdata;
	cba_pkg::status_t              status_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= cba_pkg::BLOCK_COUNT_RST;
		end else if (psel && penable && pwrite && pready
		             && paddr == cba_pkg::REG_BLOCK_COUNT) begin
			block_count_q <= pwdata[cba_pkg::CNT_REG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == cba_pkg::REG_BLOCK_COUNT)
	              ? cba_pkg::APB_DATA_W'(block_count_q) : '0;

	// Counts above the table size use the whole table.
	assign blocks = (block_count_q > cba_pkg::CNT_REG_W'(MAX_BLOCKS))
	              ? CNT_W'(MAX_BLOCKS) : CNT_W'(block_count_q);

	cba_seq #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ID_BITS    (ID_BITS),
		.AW         (AW),
		.CNT_W      (CNT_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.opcode       (opcode),
		.request_size (request_size),
		.query_id     (query_id),
		.blocks       (blocks),
		.busy         (busy),
		.ctl          (ctl),
		.addr         (addr),
		.wdata        (wdata),
		.rdata        (rdata),
		.result_valid (result_valid),
		.status       (status_w),
		.file_id      (file_id),
		.block_index  (block_index),
		.last         (last)
	);

	cba_store #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ID_BITS    (ID_BITS),
		.AW         (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.addr   (addr),
		.wdata  (wdata),
		.rdata  (rdata)
	);

	assign status = status_w;

endmodule

@@ rtl/cba_checker.sv @@
module cba_props (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_valid,
	input logic [2:0] status,
	input logic       last
);

	// An accepted item makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("block idle while results of an item are still due");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("block still busy on the final result of an item");

	// Only a found block can be followed by further results.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != cba_pkg::ST_FOUND) |-> last)
		else $error("non-search-hit result without last mark");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= cba_pkg::ST_EXHAUSTED)
		else $error("undefined status code");

endmodule

bind contiguous_block_allocator cba_props u_cba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.status       (status),
	.last         (last)
);
